// ----- design/itoc_pkg.sv -----
// Package for the incremental topological order check unit.
// Holds sizes, status codes and the sequencer state type; no dependencies.
package itoc_pkg;
	localparam int MaxNodes = 32;
	localparam int NodeW = $clog2(MaxNodes);
	localparam int CntW = NodeW + 1;

	typedef enum logic [1:0] {
		ST_UNDET = 2'd0,
		ST_UNIQUE = 2'd1,
		ST_INCONS = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_ADD_RD,
		S_ADD_WR,
		S_INIT,
		S_PICK,
		S_RD_ROW,
		S_DEC,
		S_EMIT,
		S_ONE
	} state_t;
endpackage

// ----- design/itoc_matrix_ram.sv -----
// Adjacency matrix memory: one row per source node, registered read.
// Depends on itoc_pkg.
module itoc_matrix_ram (
	input logic clk,
	input logic we,
	input logic [itoc_pkg::NodeW-1:0] waddr,
	input logic [itoc_pkg::MaxNodes-1:0] wdata,
	input logic [itoc_pkg::NodeW-1:0] raddr,
	output logic [itoc_pkg::MaxNodes-1:0] rdata
);
	logic [itoc_pkg::MaxNodes-1:0] mem [itoc_pkg::MaxNodes];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/incremental_topological_order_check_unit.sv -----
// Top level of the incremental topological order check unit.
// Depends on itoc_pkg and itoc_matrix_ram.
//
// Usage: drive start_new, before_node and after_node with start high; the
// transaction is taken when busy is low. node_count is written through
// node_count_we / node_count_wdata while the unit is idle.
// Results appear on status, order_node and last for one cycle each, marked
// by result_valid; the receiver cannot stall, results are never held.
// A start_new first sweeps the matrix, one row per cycle. Adding the edge
// takes a read and a write of one row. In-degrees are then built one
// matrix row per cycle, the last row landing in the first pick state, and
// each Kahn step runs candidate pick, row read and in-degree update, with
// one more pick to close the run. A unique order is then emitted node by
// node; any other answer is a single result. A decided graph, unless
// start_new is set, answers "ignored" in the cycle after the transaction is
// taken and is busy for that one cycle only.
// The single-port-read matrix memory sets this schedule.
// Reset clears the decided flag, node_count to 26 and marks the matrix for
// clearing: the first item after reset runs the clearing sweep too.
module incremental_topological_order_check_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic start_new,
	input logic [4:0] before_node,
	input logic [4:0] after_node,
	input logic node_count_we,
	input logic [5:0] node_count_wdata,
	output logic result_valid,
	output logic [1:0] status,
	output logic [4:0] order_node,
	output logic last
);
	localparam int N = itoc_pkg::MaxNodes;
	localparam int W = itoc_pkg::NodeW;
	localparam int C = itoc_pkg::CntW;

	itoc_pkg::state_t state_q, state_d;
	logic [5:0] node_count_q;
	logic decided_q, dirty_q;
	logic [W-1:0] a_q, b_q, idx_q, pick_q;
	logic [C-1:0] k_q, n_q;
	logic [C-1:0] indeg_q [N];
	logic [N-1:0] removed_q;
	logic multiple_q;
	logic [W-1:0] order_q [N];
	logic init_rd_q;

	logic ram_we;
	logic [W-1:0] ram_waddr, ram_raddr;
	logic [N-1:0] ram_wdata, ram_rdata;

	itoc_matrix_ram u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic [C-1:0] n_eff;
	always_comb begin
		if (node_count_q == 6'd0) n_eff = C'(1);
		else if (node_count_q > 6'(N)) n_eff = C'(N);
		else n_eff = C'(node_count_q);
	end

	logic cand_any, cand_multi;
	logic [W-1:0] pick;
	always_comb begin
		cand_any = 1'b0;
		cand_multi = 1'b0;
		pick = '0;
		for (int v = 0; v < N; v++) begin
			if (C'(v) < n_q && !removed_q[v] && indeg_q[v] == '0) begin
				cand_multi = cand_multi | cand_any;
				cand_any = 1'b1;
				pick = W'(v);
			end
		end
	end

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != itoc_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			itoc_pkg::S_IDLE: begin
				if (accept) begin
					if (start_new || (!decided_q && dirty_q)) state_d = itoc_pkg::S_CLEAR;
					else if (decided_q) state_d = itoc_pkg::S_ONE;
					else state_d = itoc_pkg::S_ADD_RD;
				end
			end
			itoc_pkg::S_CLEAR: if (idx_q == W'(N-1)) state_d = itoc_pkg::S_ADD_RD;
			itoc_pkg::S_ADD_RD: state_d = itoc_pkg::S_ADD_WR;
			itoc_pkg::S_ADD_WR: state_d = itoc_pkg::S_INIT;
			itoc_pkg::S_INIT: if (idx_q == W'(N-1)) state_d = itoc_pkg::S_PICK;
			itoc_pkg::S_PICK: begin
				if (init_rd_q) state_d = itoc_pkg::S_PICK;
				else if (k_q == n_q) state_d = multiple_q ? itoc_pkg::S_ONE : itoc_pkg::S_EMIT;
				else if (!cand_any) state_d = itoc_pkg::S_ONE;
				else state_d = itoc_pkg::S_RD_ROW;
			end
			itoc_pkg::S_RD_ROW: state_d = itoc_pkg::S_DEC;
			itoc_pkg::S_DEC: state_d = itoc_pkg::S_PICK;
			itoc_pkg::S_EMIT: if (k_q + C'(1) == n_q) state_d = itoc_pkg::S_IDLE;
			itoc_pkg::S_ONE: state_d = itoc_pkg::S_IDLE;
			default: state_d = itoc_pkg::S_IDLE;
		endcase
	end

	logic [1:0] one_status_q;
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_q;
		case (state_q)
			itoc_pkg::S_CLEAR: ram_we = 1'b1;
			itoc_pkg::S_ADD_RD: ram_raddr = a_q;
			itoc_pkg::S_ADD_WR: begin
				ram_we = 1'b1;
				ram_waddr = a_q;
				ram_wdata = ram_rdata | (N'(1) << b_q);
			end
			itoc_pkg::S_PICK: ram_raddr = pick;
			itoc_pkg::S_RD_ROW: ram_raddr = pick_q;
			default: ram_raddr = idx_q;
		endcase
		result_valid = 1'b0;
		status = itoc_pkg::ST_UNDET;
		order_node = '0;
		last = 1'b0;
		case (state_q)
			itoc_pkg::S_EMIT: begin
				result_valid = 1'b1;
				status = itoc_pkg::ST_UNIQUE;
				order_node = order_q[k_q[W-1:0]];
				last = (k_q + C'(1) == n_q);
			end
			itoc_pkg::S_ONE: begin
				result_valid = 1'b1;
				status = one_status_q;
				last = 1'b1;
			end
			default: result_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoc_pkg::S_IDLE;
			node_count_q <= 6'd26;
			decided_q <= 1'b0;
			dirty_q <= 1'b1;
			idx_q <= '0;
			k_q <= '0;
			init_rd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (node_count_we) node_count_q <= node_count_wdata;
			init_rd_q <= 1'b0;
			case (state_q)
				itoc_pkg::S_IDLE: begin
					idx_q <= '0;
					if (accept && start_new) decided_q <= 1'b0;
				end
				itoc_pkg::S_CLEAR: begin
					idx_q <= idx_q + W'(1);
					dirty_q <= 1'b0;
					decided_q <= 1'b0;
				end
				itoc_pkg::S_ADD_WR: idx_q <= '0;
				itoc_pkg::S_INIT: begin
					idx_q <= idx_q + W'(1);
					init_rd_q <= 1'b1;
					k_q <= '0;
				end
				itoc_pkg::S_PICK: begin
					if (!init_rd_q) begin
						if (k_q == n_q) begin
							if (!multiple_q) decided_q <= 1'b1;
							k_q <= '0;
						end else if (!cand_any) decided_q <= 1'b1;
					end
				end
				itoc_pkg::S_DEC: k_q <= k_q + C'(1);
				itoc_pkg::S_EMIT: k_q <= k_q + C'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == itoc_pkg::S_IDLE && accept) begin
			a_q <= before_node;
			b_q <= after_node;
			n_q <= n_eff;
			one_status_q <= itoc_pkg::ST_IGNORED;
		end
		if (state_q == itoc_pkg::S_ADD_WR) begin
			removed_q <= '0;
			multiple_q <= 1'b0;
			for (int v = 0; v < N; v++) indeg_q[v] <= '0;
		end
		if (init_rd_q) begin
			for (int v = 0; v < N; v++) indeg_q[v] <= indeg_q[v] + C'(ram_rdata[v]);
		end
		if (state_q == itoc_pkg::S_INIT && idx_q == W'(N-1)) begin
			one_status_q <= itoc_pkg::ST_UNDET;
		end
		if (state_q == itoc_pkg::S_PICK && !init_rd_q) begin
			if (k_q == n_q) one_status_q <= itoc_pkg::ST_UNDET;
			else if (!cand_any) one_status_q <= itoc_pkg::ST_INCONS;
			else begin
				if (cand_multi) multiple_q <= 1'b1;
				pick_q <= pick;
				order_q[k_q[W-1:0]] <= pick;
				removed_q[pick] <= 1'b1;
			end
		end
		if (state_q == itoc_pkg::S_DEC) begin
			for (int v = 0; v < N; v++) begin
				if (ram_rdata[v] && indeg_q[v] != '0) indeg_q[v] <= indeg_q[v] - C'(1);
			end
		end
	end
endmodule

// ----- dv/tb_incremental_topological_order_check_unit.sv -----
// Self-checking testbench for incremental_topological_order_check_unit.
// Depends on itoc_pkg and the unit's RTL; an internal scoreboard reruns Kahn's
// algorithm on every accepted transaction and compares each result strobe.
module tb_incremental_topological_order_check_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		itoc_pkg::status_t st;
		logic [4:0] node;
		logic last;
	} order_result_t;

	class order_scoreboard;
		logic [31:0] rows [32];
		bit decided;
		int node_count;
		int errors;
		int uniques;
		order_result_t pending [$];

		function void clear_all();
			foreach (rows[i])
				rows[i] = '0;
			decided = 0;
			node_count = 26;
			errors = 0;
			uniques = 0;
		endfunction

		function int span();
			int c;
			c = node_count;
			if (c == 0)
				c = 1;
			if (c > itoc_pkg::MaxNodes)
				c = itoc_pkg::MaxNodes;
			return c;
		endfunction

		function void note(bit fresh, logic [4:0] a, logic [4:0] b);
			int n, cand, pick, k;
			bit multi;
			int indeg [32];
			bit gone [32];
			logic [4:0] seq [32];
			itoc_pkg::status_t st;
			order_result_t r;
			n = span();
			if (fresh) begin
				foreach (rows[i])
					rows[i] = '0;
				decided = 0;
			end
			if (decided) begin
				r.st = itoc_pkg::ST_IGNORED; r.node = '0; r.last = 1'b1;
				pending = {pending, r};
				return;
			end
			rows[a][b] = 1'b1;
			for (int v = 0; v < 32; v++) begin
				indeg[v] = 0;
				gone[v] = 0;
				for (int u = 0; u < 32; u++)
					indeg[v] += rows[u][v];
			end
			st = itoc_pkg::ST_UNIQUE;
			multi = 0;
			for (k = 0; k < n; k++) begin
				cand = 0;
				pick = 0;
				for (int v = 0; v < n; v++)
					if (!gone[v] && indeg[v] == 0) begin
						cand++;
						pick = v;
					end
				if (cand == 0) begin
					st = itoc_pkg::ST_INCONS;
					break;
				end
				if (cand > 1)
					multi = 1;
				seq[k] = pick[4:0];
				gone[pick] = 1;
				for (int v = 0; v < 32; v++)
					if (rows[pick][v] && indeg[v] > 0)
						indeg[v]--;
			end
			if (st == itoc_pkg::ST_UNIQUE && multi)
				st = itoc_pkg::ST_UNDET;
			if (st == itoc_pkg::ST_UNIQUE) begin
				decided = 1;
				uniques++;
				for (k = 0; k < n; k++) begin
					r.st = itoc_pkg::ST_UNIQUE; r.node = seq[k]; r.last = (k == n - 1);
					pending = {pending, r};
				end
				return;
			end
			if (st == itoc_pkg::ST_INCONS)
				decided = 1;
			r.st = st; r.node = '0; r.last = 1'b1;
			pending = {pending, r};
		endfunction

		function void check(logic [1:0] st, logic [4:0] node, logic lst);
			order_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d order_node %0d last %0d", st, node, lst);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
			if (node !== e.node) begin
				$error("order_node: expected %0d, actual %0d", e.node, node);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic start_new = 1'b0;
	logic [4:0] before_node = '0;
	logic [4:0] after_node = '0;
	logic node_count_we = 1'b0;
	logic [5:0] node_count_wdata = '0;
	logic result_valid;
	logic [1:0] status;
	logic [4:0] order_node;
	logic last;

	order_scoreboard sb = new();
	int gap_pct;
	int relations;
	int settings;
	int quiet;

	incremental_topological_order_check_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_new(start_new),
		.before_node(before_node),
		.after_node(after_node),
		.node_count_we(node_count_we),
		.node_count_wdata(node_count_wdata),
		.result_valid(result_valid),
		.status(status),
		.order_node(order_node),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check(status, order_node, last);
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send(bit fresh, logic [4:0] a, logic [4:0] b);
		start <= 1'b1;
		start_new <= fresh;
		before_node <= a;
		after_node <= b;
		do
			@(posedge clk);
		while (busy);
		sb.note(fresh, a, b);
		relations++;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_count(logic [5:0] v);
		drain();
		node_count_we <= 1'b1;
		node_count_wdata <= v;
		@(posedge clk);
		node_count_we <= 1'b0;
		sb.node_count = int'(v);
		settings++;
	endtask

	task automatic run_sequence(int n);
		int perm [32];
		logic [4:0] ea [$];
		logic [4:0] eb [$];
		int j, t, len;
		bit noisy;
		for (int i = 0; i < n; i++)
			perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = perm[i]; perm[i] = perm[j]; perm[j] = t;
		end
		for (int i = 0; i + 1 < n; i++) begin
			ea = {ea, 5'(perm[i])};
			eb = {eb, 5'(perm[i + 1])};
		end
		if (n > 2)
			for (int i = $urandom_range(3); i > 0; i--) begin
				j = $urandom_range(n - 2);
				t = $urandom_range(j + 1, n - 1);
				ea = {ea, 5'(perm[j])};
				eb = {eb, 5'(perm[t])};
			end
		noisy = ($urandom_range(99) < 25);
		if (noisy || ea.size() == 0) begin
			ea = {ea, 5'($urandom_range(31))};
			eb = {eb, 5'($urandom_range(31))};
		end
		len = ea.size();
		for (int i = len - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = int'(ea[i]); ea[i] = ea[j]; ea[j] = t[4:0];
			t = int'(eb[i]); eb[i] = eb[j]; eb[j] = t[4:0];
		end
		for (int i = 0; i < len; i++) begin
			send(i == 0, ea[i], eb[i]);
			if (sb.decided)
				break;
		end
		if ($urandom_range(3) == 0)
			send(1'b0, 5'($urandom_range(31)), 5'($urandom_range(31)));
	endtask

	initial begin
		int target, n;
		int picks [6];
		logic [5:0] w;
		picks = '{0, 1, 32, 63, 33, 20};
		sb.clear_all();
		relations = 0;
		settings = 0;
		quiet = 0;
		gap_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(1'b1, 5'd0, 5'd25);
		send(1'b0, 5'd31, 5'd0);
		set_count(6'd4);
		send(1'b1, 5'd1, 5'd1);
		send(1'b0, 5'd2, 5'd3);
		send(1'b1, 5'd0, 5'd1);
		send(1'b0, 5'd0, 5'd1);
		send(1'b0, 5'd1, 5'd2);
		send(1'b0, 5'd2, 5'd3);
		send(1'b0, 5'd3, 5'd0);
		send(1'b1, 5'd3, 5'd31);
		send(1'b0, 5'd31, 5'd0);
		send(1'b0, 5'd1, 5'd2);
		send(1'b0, 5'd2, 5'd3);
		send(1'b0, 5'd1, 5'd0);
		send(1'b1, 5'd2, 5'd1);
		send(1'b0, 5'd3, 5'd1);
		send(1'b0, 5'd2, 5'd0);
		send(1'b0, 5'd1, 5'd0);
		set_count(6'd0);
		send(1'b1, 5'd5, 5'd6);
		send(1'b1, 5'd0, 5'd0);
		set_count(6'd63);
		send(1'b1, 5'd31, 5'd30);

		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 16 : (phase == 1) ? 62 : 0;
			target = relations + 150;
			while (relations < target) begin
				if ($urandom_range(99) < 75)
					w = 6'($urandom_range(2, 8));
				else
					w = 6'(picks[$urandom_range(5)]);
				set_count(w);
				n = sb.span();
				run_sequence(n);
			end
			drain();
		end

		drain();
		$display("Covered %0d transactions over %0d node-count settings; %0d unique orders.",
			relations, settings, sb.uniques);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
